// ===== design/satc_pkg.sv =====
// Shared constants, codes and trig table generator for the rotated rectangle collision block.
package satc_pkg;

    localparam int ANG_W = 9;
    localparam int RED_W = 7;
    localparam logic [ANG_W-1:0] DEG_FULL = 9'd360;
    localparam logic [ANG_W-1:0] DEG_HALF = 9'd180;
    localparam logic [ANG_W-1:0] DEG_QTR  = 9'd90;
    localparam logic [ANG_W-1:0] DEG_3QTR = 9'd270;
    localparam int QTR_TAB = 90;
    localparam int BASE_MAX = 45;
    localparam int NUM_AX = 4;
    localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;

    typedef enum logic [1:0] {QD0, QD1, QD2, QD3} quad_t;

    // Q60 multiply, truncated
    function automatic logic [63:0] qmul60(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[123:60];
    endfunction

    // sin or cos of r degrees (0..45), Taylor sum in Q60, rounded to frac bits
    function automatic longint base_trig(input int r, input int frac, input bit want_cos);
        logic [63:0] step;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] st;
        logic [63:0] ss;
        logic [63:0] ct;
        logic [63:0] cs;
        logic [63:0] v;
        int sh;
        step = (PI_Q60 + 64'd90) / 64'(DEG_HALF);
        x = 64'(r) * step;
        x2 = qmul60(x, x);
        st = x;
        ss = x;
        ct = 64'd1 << 60;
        cs = 64'd1 << 60;
        for (int n = 1; n <= 14; n++)
        begin
            st = qmul60(st, x2) / 64'((2 * n) * (2 * n + 1));
            ct = qmul60(ct, x2) / 64'((2 * n - 1) * (2 * n));
            if (n % 2 == 1)
            begin
                ss = ss - st;
                cs = cs - ct;
            end
            else
            begin
                ss = ss + st;
                cs = cs + ct;
            end
        end
        sh = 60 - frac;
        v = want_cos ? cs : ss;
        return longint'((v + (64'd1 << (sh - 1))) >> sh);
    endfunction

endpackage

// ===== design/satc_if.sv =====
// Request and response channel interfaces of the rotated rectangle collision block.
interface satc_req_if #(parameter int COORD_BITS = 16);
    logic valid;
    logic ready;
    logic signed [COORD_BITS-1:0] a_x;
    logic signed [COORD_BITS-1:0] a_y;
    logic [COORD_BITS-2:0] a_w;
    logic [COORD_BITS-2:0] a_h;
    logic [8:0] a_angle;
    logic signed [COORD_BITS-1:0] b_x;
    logic signed [COORD_BITS-1:0] b_y;
    logic [COORD_BITS-2:0] b_w;
    logic [COORD_BITS-2:0] b_h;
    logic [8:0] b_angle;

    modport source (output valid, a_x, a_y, a_w, a_h, a_angle, b_x, b_y, b_w, b_h, b_angle,
                    input ready);
    modport sink (input valid, a_x, a_y, a_w, a_h, a_angle, b_x, b_y, b_w, b_h, b_angle,
                  output ready);
endinterface

interface satc_rsp_if;
    logic valid;
    logic ready;
    logic collide;

    modport source (output valid, collide, input ready);
    modport sink (input valid, collide, output ready);
endinterface

// ===== design/rotated_rect_sat_collision.sv =====
// A request accepted into the first register stage becomes a valid response at the last
// (9 register stages); one request per cycle sustained while the response is not stalled.
// Throughput is set by a 9-stage pipeline that advances as a whole whenever the output
// register is empty or being taken; a stalled response holds every stage in place.
// Reset (rst_n low, async) clears all stage valid bits; payload registers are not reset.
// Trig tables are constants built at elaboration, so no clearing pass is needed.
module rotated_rect_sat_collision
    import satc_pkg::*;
#(
    parameter int COORD_BITS = 16,
    parameter int TRIG_FRAC_BITS = 14
)(
    input  logic clk,
    input  logic rst_n,
    satc_req_if.sink req,
    satc_rsp_if.source rsp
);

    localparam int CB = COORD_BITS;
    localparam int F  = TRIG_FRAC_BITS;
    localparam int TW = F + 2;            // signed trig value, |v| <= 2^F
    localparam int CW = CB + 1 + F;       // centre scaled by 2^F
    localparam int MW = CB + F;           // offset times trig
    localparam int PW = CB + F + 2;       // corner coordinate
    localparam int XW = CB + 2 * F + 2;   // corner times axis component
    localparam int DW = CB + 2 * F + 3;   // projection
    localparam int NS = 9;

    typedef logic signed [TW-1:0] tab_t [0:QTR_TAB-1];

    function automatic tab_t build_tab(input bit want_cos);
        tab_t t;
        longint v;
        for (int r = 0; r < QTR_TAB; r++)
        begin
            if (r <= BASE_MAX)
                v = base_trig(r, F, want_cos);
            else
                v = base_trig(QTR_TAB - r, F, !want_cos);
            t[r] = TW'(v);
        end
        return t;
    endfunction

    localparam tab_t SIN_TAB = build_tab(1'b0);
    localparam tab_t COS_TAB = build_tab(1'b1);

    // pipeline control: whole pipe advances unless the output register is stalled
    logic [NS:1] v_reg;
    logic        adv;

    assign adv = !v_reg[NS] || rsp.ready;
    assign req.ready = adv;
    assign rsp.valid = v_reg[NS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (adv)
            v_reg <= {v_reg[NS-1:1], req.valid};
    end

    // ---------------- stage 1: capture, angle reduce, quadrant split
    logic signed [CB-1:0] in_x [2];
    logic signed [CB-1:0] in_y [2];
    logic [CB-2:0]        in_w [2];
    logic [CB-2:0]        in_h [2];
    logic [ANG_W-1:0]     in_a [2];
    logic [ANG_W-1:0]     ang_m [2];
    quad_t                q_next [2];
    logic [RED_W-1:0]     r_next [2];

    assign in_x[0] = req.a_x;  assign in_x[1] = req.b_x;
    assign in_y[0] = req.a_y;  assign in_y[1] = req.b_y;
    assign in_w[0] = req.a_w;  assign in_w[1] = req.b_w;
    assign in_h[0] = req.a_h;  assign in_h[1] = req.b_h;
    assign in_a[0] = req.a_angle;  assign in_a[1] = req.b_angle;

    always_comb
    begin
        for (int i = 0; i < 2; i++)
        begin
            ang_m[i] = (in_a[i] >= DEG_FULL) ? in_a[i] - DEG_FULL : in_a[i];
            if (ang_m[i] >= DEG_3QTR)
            begin
                q_next[i] = QD3;
                r_next[i] = RED_W'(ang_m[i] - DEG_3QTR);
            end
            else if (ang_m[i] >= DEG_HALF)
            begin
                q_next[i] = QD2;
                r_next[i] = RED_W'(ang_m[i] - DEG_HALF);
            end
            else if (ang_m[i] >= DEG_QTR)
            begin
                q_next[i] = QD1;
                r_next[i] = RED_W'(ang_m[i] - DEG_QTR);
            end
            else
            begin
                q_next[i] = QD0;
                r_next[i] = RED_W'(ang_m[i]);
            end
        end
    end

    logic signed [CB-1:0] x1_reg [2];
    logic signed [CB-1:0] y1_reg [2];
    logic [CB-2:0]        w1_reg [2];
    logic [CB-2:0]        h1_reg [2];
    quad_t                q1_reg [2];
    logic [RED_W-1:0]     r1_reg [2];
    logic [NS:1]          z_reg;       // some size is zero: answer is no hit

    // ---------------- stage 2: trig lookup, offsets, scaled centre
    logic signed [TW-1:0] c2_reg [2];
    logic signed [TW-1:0] s2_reg [2];
    logic signed [CB-1:0] dx2_reg [2][2];
    logic signed [CB-1:0] dy2_reg [2][2];
    logic signed [CW-1:0] cx2_reg [2];
    logic signed [CW-1:0] cy2_reg [2];

    logic signed [TW-1:0] sv [2];
    logic signed [TW-1:0] cv [2];
    logic signed [TW-1:0] c_next [2];
    logic signed [TW-1:0] s_next [2];
    logic signed [CB:0]   cen_x [2];
    logic signed [CB:0]   cen_y [2];
    logic [CB-2:0]        hw [2];
    logic [CB-2:0]        hh [2];

    always_comb
    begin
        for (int i = 0; i < 2; i++)
        begin
            sv[i] = SIN_TAB[r1_reg[i]];
            cv[i] = COS_TAB[r1_reg[i]];
            unique case (q1_reg[i])
                QD0:     begin s_next[i] = sv[i];  c_next[i] = cv[i];  end
                QD1:     begin s_next[i] = cv[i];  c_next[i] = -sv[i]; end
                QD2:     begin s_next[i] = -sv[i]; c_next[i] = -cv[i]; end
                QD3:     begin s_next[i] = -cv[i]; c_next[i] = sv[i];  end
                default: begin s_next[i] = sv[i];  c_next[i] = cv[i];  end
            endcase
            hw[i] = w1_reg[i] >> 1;
            hh[i] = h1_reg[i] >> 1;
            cen_x[i] = (CB+1)'(x1_reg[i]) + signed'({2'b00, hw[i]});
            cen_y[i] = (CB+1)'(y1_reg[i]) + signed'({2'b00, hh[i]});
        end
    end

    // ---------------- stage 3: offset by trig products
    logic signed [MW-1:0] dxc3_reg [2][2];
    logic signed [MW-1:0] dxs3_reg [2][2];
    logic signed [MW-1:0] dyc3_reg [2][2];
    logic signed [MW-1:0] dys3_reg [2][2];
    logic signed [CW-1:0] cx3_reg [2];
    logic signed [CW-1:0] cy3_reg [2];
    logic signed [TW-1:0] c3_reg [2];
    logic signed [TW-1:0] s3_reg [2];

    // ---------------- stage 4: corners and axes
    logic signed [PW-1:0] px4_reg [2][4];
    logic signed [PW-1:0] py4_reg [2][4];
    logic signed [TW-1:0] ux4_reg [NUM_AX];
    logic signed [TW-1:0] uy4_reg [NUM_AX];

    // ---------------- stages 5..9: projections, min/max, overlap
    logic signed [XW-1:0] prx5_reg [NUM_AX][2][4];
    logic signed [XW-1:0] pry5_reg [NUM_AX][2][4];
    logic signed [DW-1:0] d6_reg [NUM_AX][2][4];
    logic signed [DW-1:0] lo7_reg [NUM_AX][2][2];
    logic signed [DW-1:0] hi7_reg [NUM_AX][2][2];
    logic signed [DW-1:0] mn8_reg [NUM_AX][2];
    logic signed [DW-1:0] mx8_reg [NUM_AX][2];
    logic [NUM_AX-1:0]    ovl;
    logic                 col_reg;

    always_comb
    begin
        for (int a = 0; a < NUM_AX; a++)
            ovl[a] = !(mx8_reg[a][0] < mn8_reg[a][1]) && (mn8_reg[a][0] < mx8_reg[a][1]);
    end

    assign rsp.collide = col_reg;

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            z_reg[1] <= (in_w[0] == '0) || (in_h[0] == '0) ||
                        (in_w[1] == '0) || (in_h[1] == '0);
            z_reg[NS:2] <= z_reg[NS-1:1];
            for (int i = 0; i < 2; i++)
            begin
                // stage 1
                x1_reg[i] <= in_x[i];
                y1_reg[i] <= in_y[i];
                w1_reg[i] <= in_w[i];
                h1_reg[i] <= in_h[i];
                q1_reg[i] <= q_next[i];
                r1_reg[i] <= r_next[i];
                // stage 2
                c2_reg[i] <= c_next[i];
                s2_reg[i] <= s_next[i];
                dx2_reg[i][0] <= -signed'({1'b0, hw[i]});
                dx2_reg[i][1] <= signed'({1'b0, w1_reg[i] - hw[i]});
                dy2_reg[i][0] <= -signed'({1'b0, hh[i]});
                dy2_reg[i][1] <= signed'({1'b0, h1_reg[i] - hh[i]});
                cx2_reg[i] <= {cen_x[i], F'(0)};
                cy2_reg[i] <= {cen_y[i], F'(0)};
                // stage 3
                for (int j = 0; j < 2; j++)
                begin
                    dxc3_reg[i][j] <= MW'(dx2_reg[i][j]) * MW'(c2_reg[i]);
                    dxs3_reg[i][j] <= MW'(dx2_reg[i][j]) * MW'(s2_reg[i]);
                    dyc3_reg[i][j] <= MW'(dy2_reg[i][j]) * MW'(c2_reg[i]);
                    dys3_reg[i][j] <= MW'(dy2_reg[i][j]) * MW'(s2_reg[i]);
                end
                cx3_reg[i] <= cx2_reg[i];
                cy3_reg[i] <= cy2_reg[i];
                c3_reg[i] <= c2_reg[i];
                s3_reg[i] <= s2_reg[i];
                // stage 4: corner k uses x offset k/2 and y offset k%2
                for (int k = 0; k < 4; k++)
                begin
                    px4_reg[i][k] <= PW'(cx3_reg[i]) + PW'(dxc3_reg[i][k / 2])
                                     - PW'(dys3_reg[i][k % 2]);
                    py4_reg[i][k] <= PW'(cy3_reg[i]) + PW'(dxs3_reg[i][k / 2])
                                     + PW'(dyc3_reg[i][k % 2]);
                end
            end
            // edge normals of each rectangle
            for (int i = 0; i < 2; i++)
            begin
                ux4_reg[2 * i]     <= -c3_reg[i];
                uy4_reg[2 * i]     <= -s3_reg[i];
                ux4_reg[2 * i + 1] <= -s3_reg[i];
                uy4_reg[2 * i + 1] <= c3_reg[i];
            end
            for (int a = 0; a < NUM_AX; a++)
            begin
                for (int i = 0; i < 2; i++)
                begin
                    for (int k = 0; k < 4; k++)
                    begin
                        prx5_reg[a][i][k] <= XW'(px4_reg[i][k]) * XW'(ux4_reg[a]);
                        pry5_reg[a][i][k] <= XW'(py4_reg[i][k]) * XW'(uy4_reg[a]);
                        d6_reg[a][i][k] <= DW'(prx5_reg[a][i][k]) + DW'(pry5_reg[a][i][k]);
                    end
                    for (int p = 0; p < 2; p++)
                    begin
                        lo7_reg[a][i][p] <= (d6_reg[a][i][2*p] < d6_reg[a][i][2*p+1]) ?
                                            d6_reg[a][i][2*p] : d6_reg[a][i][2*p+1];
                        hi7_reg[a][i][p] <= (d6_reg[a][i][2*p] < d6_reg[a][i][2*p+1]) ?
                                            d6_reg[a][i][2*p+1] : d6_reg[a][i][2*p];
                    end
                    mn8_reg[a][i] <= (lo7_reg[a][i][0] < lo7_reg[a][i][1]) ?
                                     lo7_reg[a][i][0] : lo7_reg[a][i][1];
                    mx8_reg[a][i] <= (hi7_reg[a][i][0] < hi7_reg[a][i][1]) ?
                                     hi7_reg[a][i][1] : hi7_reg[a][i][0];
                end
            end
            // stage 9: all axes overlap and no degenerate rectangle
            col_reg <= (&ovl) && !z_reg[NS-1];
        end
    end

    // ---------------- checks
    a_stall_blocks_req: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && !rsp.ready |-> !req.ready)
        else $error("request taken while response stalled");

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready |=> v_reg[1])
        else $error("accepted request lost at pipe entry");

    a_zero_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[NS] && z_reg[NS] |-> !rsp.collide)
        else $error("zero-size rectangle reported as colliding");

endmodule

// ===== test/tb.sv =====
// Testbench for the rotated rectangle collision block: directed and random rectangle pairs.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import satc_pkg::*;

    // One rectangle as the predictor sees it
    typedef struct {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [14:0] w;
        logic [14:0] h;
        logic [8:0] ang;
    } rect_t;

    logic clk;
    logic rst_n;

    satc_req_if #(.COORD_BITS(16)) req ();
    satc_rsp_if rsp ();

    rotated_rect_sat_collision uut (
        .clk(clk),
        .rst_n(rst_n),
        .req(req),
        .rsp(rsp)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // Sine and cosine tables, Q1.14, built from our own Taylor sum
    longint sin_q[360];
    longint cos_q[360];

    // Expected collide bits, oldest first
    bit hit_queue[$];
    int errors = 0;
    int n_sent = 0;
    int n_checked = 0;
    int n_hits = 0;
    // Percent chance of idling on each side
    int send_idle = 0;
    int recv_stall = 0;
    // Long receiver hold-off, set by its own cycle-counting process
    bit hold_on = 1'b0;

    function automatic logic [63:0] q60_mul(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[123:60];
    endfunction

    // Taylor sum for 0..45 degrees; sel_cos picks the cosine
    function automatic longint taylor_deg(input int r, input bit sel_cos);
        logic [63:0] stp;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] st;
        logic [63:0] ss;
        logic [63:0] ct;
        logic [63:0] cs;
        logic [63:0] v;
        stp = (64'h3243F6A8885A308D + 64'd90) / 64'd180;
        x = 64'(r) * stp;
        x2 = q60_mul(x, x);
        st = x;
        ss = x;
        ct = 64'd1 << 60;
        cs = 64'd1 << 60;
        for (int n = 1; n <= 14; n++)
        begin
            st = q60_mul(st, x2) / 64'((2 * n) * (2 * n + 1));
            ct = q60_mul(ct, x2) / 64'((2 * n - 1) * (2 * n));
            if (n % 2 == 1)
            begin
                ss = ss - st;
                cs = cs - ct;
            end
            else
            begin
                ss = ss + st;
                cs = cs + ct;
            end
        end
        v = sel_cos ? cs : ss;
        return longint'((v + (64'd1 << 45)) >> 46);
    endfunction

    task automatic build_trig();
        int r;
        longint s0;
        longint c0;
        for (int d = 0; d < 360; d++)
        begin
            r = d % 90;
            if (r <= 45)
            begin
                s0 = taylor_deg(r, 1'b0);
                c0 = taylor_deg(r, 1'b1);
            end
            else
            begin
                c0 = taylor_deg(90 - r, 1'b0);
                s0 = taylor_deg(90 - r, 1'b1);
            end
            case (d / 90)
                0: begin sin_q[d] = s0; cos_q[d] = c0; end
                1: begin sin_q[d] = c0; cos_q[d] = -s0; end
                2: begin sin_q[d] = -s0; cos_q[d] = -c0; end
                default: begin sin_q[d] = -c0; cos_q[d] = s0; end
            endcase
        end
    endtask

    // Corner k of a rectangle in Q.14, rotated about its centre
    function automatic void rect_corners(input rect_t rc, output longint px[4],
                                         output longint py[4]);
        longint hw;
        longint hh;
        longint cx;
        longint cy;
        longint dx;
        longint dy;
        longint c;
        longint s;
        hw = longint'(rc.w) / 2;
        hh = longint'(rc.h) / 2;
        cx = (longint'(rc.x) + hw) * 16384;
        cy = (longint'(rc.y) + hh) * 16384;
        c = cos_q[rc.ang % 360];
        s = sin_q[rc.ang % 360];
        for (int k = 0; k < 4; k++)
        begin
            dx = (k >> 1) ? longint'(rc.w) - hw : -hw;
            dy = (k & 1) ? longint'(rc.h) - hh : -hh;
            px[k] = cx + dx * c - dy * s;
            py[k] = cy + dx * s + dy * c;
        end
    endfunction

    // Projections fit easily in 128 signed bits
    function automatic bit axis_overlap(input longint ax[4], input longint ay[4],
                                        input longint bx[4], input longint by[4],
                                        input longint ux, input longint uy);
        logic signed [127:0] d;
        logic signed [127:0] amn;
        logic signed [127:0] amx;
        logic signed [127:0] bmn;
        logic signed [127:0] bmx;
        for (int k = 0; k < 4; k++)
        begin
            d = 128'(ax[k]) * 128'(ux) + 128'(ay[k]) * 128'(uy);
            if (k == 0 || d < amn) amn = d;
            if (k == 0 || d > amx) amx = d;
            d = 128'(bx[k]) * 128'(ux) + 128'(by[k]) * 128'(uy);
            if (k == 0 || d < bmn) bmn = d;
            if (k == 0 || d > bmx) bmx = d;
        end
        return (bmn <= amx) && (amn < bmx);
    endfunction

    function automatic bit predict_collide(input rect_t a, input rect_t b);
        longint ax[4];
        longint ay[4];
        longint bx[4];
        longint by[4];
        longint ac;
        longint as_;
        longint bc;
        longint bs;
        if (a.w == 0 || a.h == 0 || b.w == 0 || b.h == 0)
            return 1'b0;
        rect_corners(a, ax, ay);
        rect_corners(b, bx, by);
        ac = cos_q[a.ang % 360];
        as_ = sin_q[a.ang % 360];
        bc = cos_q[b.ang % 360];
        bs = sin_q[b.ang % 360];
        return axis_overlap(ax, ay, bx, by, -ac, -as_) &&
               axis_overlap(ax, ay, bx, by, -as_, ac) &&
               axis_overlap(ax, ay, bx, by, -bc, -bs) &&
               axis_overlap(ax, ay, bx, by, -bs, bc);
    endfunction

    // Offer one request, with optional idle cycles first, and wait for acceptance
    task automatic send_pair(input rect_t a, input rect_t b);
        while (send_idle > 0 && $urandom_range(99) < send_idle)
        begin
            req.valid <= 1'b0;
            @(posedge clk);
        end
        req.valid <= 1'b1;
        req.a_x <= a.x;
        req.a_y <= a.y;
        req.a_w <= a.w;
        req.a_h <= a.h;
        req.a_angle <= a.ang;
        req.b_x <= b.x;
        req.b_y <= b.y;
        req.b_w <= b.w;
        req.b_h <= b.h;
        req.b_angle <= b.ang;
        hit_queue.push_back(predict_collide(a, b));
        n_sent++;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
    endtask

    task automatic go_idle();
        req.valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic rect_t mk_rect(input int x, input int y, input int w, input int h,
                                      input int ang);
        rect_t r;
        r.x = 16'(x);
        r.y = 16'(y);
        r.w = 15'(w);
        r.h = 15'(h);
        r.ang = 9'(ang);
        return r;
    endfunction

    // Mostly small rectangles placed near each other, so both outcomes occur
    function automatic rect_t rand_near(input int cx, input int cy);
        rect_t r;
        int sel;
        sel = $urandom_range(99);
        r.w = (sel < 80) ? 15'($urandom_range(1, 200)) : 15'($urandom);
        r.h = (sel < 80) ? 15'($urandom_range(1, 200)) : 15'($urandom);
        if (sel < 4) r.w = 15'd0;
        r.x = 16'(cx + int'($urandom_range(0, 400)) - 200);
        r.y = 16'(cy + int'($urandom_range(0, 400)) - 200);
        if (sel >= 95)
        begin
            r.x = 16'($urandom);
            r.y = 16'($urandom);
        end
        r.ang = ($urandom_range(9) == 0) ? 9'($urandom_range(0, 3) * 90)
                                         : 9'($urandom_range(359));
        return r;
    endfunction

    task automatic random_burst(input int count);
        int cx;
        int cy;
        for (int i = 0; i < count; i++)
        begin
            cx = int'($urandom_range(0, 60000)) - 30000;
            cy = int'($urandom_range(0, 60000)) - 30000;
            send_pair(rand_near(cx, cy), rand_near(cx, cy));
        end
        go_idle();
    endtask

    // Extremes of every field, zero sizes, touching edges, right angles
    task automatic test_directed();
        send_pair(mk_rect(0, 0, 10, 10, 0), mk_rect(5, 5, 10, 10, 0));
        send_pair(mk_rect(0, 0, 10, 10, 0), mk_rect(10, 0, 10, 10, 0));
        send_pair(mk_rect(10, 0, 10, 10, 0), mk_rect(0, 0, 10, 10, 0));
        send_pair(mk_rect(0, 0, 10, 10, 0), mk_rect(0, 10, 10, 10, 0));
        send_pair(mk_rect(0, 0, 10, 10, 0), mk_rect(9, 9, 10, 10, 0));
        send_pair(mk_rect(0, 0, 0, 10, 0), mk_rect(0, 0, 10, 10, 0));
        send_pair(mk_rect(0, 0, 10, 10, 0), mk_rect(0, 0, 10, 0, 0));
        send_pair(mk_rect(0, 0, 10, 0, 0), mk_rect(0, 0, 0, 10, 0));
        send_pair(mk_rect(0, 0, 1, 1, 0), mk_rect(0, 0, 1, 1, 0));
        send_pair(mk_rect(0, 0, 100, 4, 45), mk_rect(60, 60, 4, 4, 0));
        send_pair(mk_rect(0, 0, 100, 4, 45), mk_rect(45, 45, 4, 4, 0));
        send_pair(mk_rect(0, 0, 20, 20, 45), mk_rect(23, 0, 20, 20, 45));
        send_pair(mk_rect(0, 0, 40, 10, 90), mk_rect(15, -14, 10, 10, 0));
        send_pair(mk_rect(0, 0, 40, 10, 180), mk_rect(38, 0, 10, 10, 270));
        send_pair(mk_rect(0, 0, 40, 10, 359), mk_rect(-5, 0, 10, 10, 1));
        send_pair(mk_rect(-32768, -32768, 32767, 32767, 359),
                  mk_rect(32767, 32767, 32767, 32767, 359));
        send_pair(mk_rect(-32768, -32768, 32767, 32767, 0),
                  mk_rect(-32768, -32768, 32767, 32767, 180));
        send_pair(mk_rect(32767, 32767, 32767, 32767, 0),
                  mk_rect(-1, -1, 32767, 32767, 45));
        send_pair(mk_rect(-32768, 32767, 1, 32767, 270),
                  mk_rect(32767, -32768, 32767, 1, 90));
        send_pair(mk_rect(-100, -100, 200, 200, 30), mk_rect(-5, -5, 10, 10, 330));
        send_pair(mk_rect(0, 0, 21845, 10922, 123), mk_rect(0, 0, 10922, 21845, 256));
        send_pair(mk_rect(-21846, 21845, 5, 7, 170), mk_rect(-21846, 21845, 7, 5, 85));
        go_idle();
    endtask

    task automatic test_random_phases();
        send_idle = 0;  recv_stall = 0;  random_burst(150);
        send_idle = 50; recv_stall = 0;  random_burst(120);
        send_idle = 0;  recv_stall = 50; random_burst(120);
        send_idle = 21; recv_stall = 21; random_burst(120);
    endtask

    // Receiver holds off long enough for the pipeline to fill and stall input
    task automatic test_backpressure();
        send_idle = 0;
        recv_stall = 0;
        fork
            begin
                hold_on <= 1'b1;
                repeat (40) @(posedge clk);
                hold_on <= 1'b0;
            end
        join_none
        random_burst(60);
    endtask

    // Response side: random stalls, the hold-off, and checking
    always @(posedge clk)
    begin
        bit exp_hit;
        if (!rst_n)
            rsp.ready <= 1'b0;
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (hit_queue.size() == 0)
                begin
                    $display("%0t: unexpected response collide=%0b", $time, rsp.collide);
                    errors++;
                end
                else
                begin
                    exp_hit = hit_queue.pop_front();
                    n_checked++;
                    if (exp_hit)
                        n_hits++;
                    if (rsp.collide !== exp_hit)
                    begin
                        $display("%0t: collide mismatch expected %0b actual %0b",
                                 $time, exp_hit, rsp.collide);
                        errors++;
                    end
                end
            end
            if (hold_on)
                rsp.ready <= 1'b0;
            else
                rsp.ready <= !(recv_stall > 0 && $urandom_range(99) < recv_stall);
        end
    end

    initial
    begin
        req.valid = 1'b0;
        req.a_x = '0;
        req.a_y = '0;
        req.a_w = '0;
        req.a_h = '0;
        req.a_angle = '0;
        req.b_x = '0;
        req.b_y = '0;
        req.b_w = '0;
        req.b_h = '0;
        req.b_angle = '0;
        rst_n = 1'b0;
        build_trig();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random_phases();
        test_backpressure();
        send_idle = 0;
        recv_stall = 0;
        while (hit_queue.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        $display("Sent %0d rectangle pairs, checked %0d responses (%0d overlaps)",
                 n_sent, n_checked, n_hits);
        $display("Covered edge cases, all angles, idle and stall mixes, and a long hold-off");
        if (errors == 0 && hit_queue.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        #400us;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
